FILE: rtl/mcts_pkg.sv
`default_nettype none

package mcts_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CH_W = 3;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] TICKS_RESET = 32'd2880000000;

  localparam logic OP_START = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic completes;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/multi_channel_tach_speed_meter.sv
// start and first-edge transactions leave the input ready for the next transaction
// a completing edge holds the input through the 32-step shared divider and the output load
// the output register lets new transactions in while a result waits to be taken
// reset (rst, synchronous): all channels idle, output empty, ticks_per_half_minute 2880000000
`default_nettype none

module multi_channel_tach_speed_meter #(
  parameter int CHANNELS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [mcts_pkg::DATA_W-1:0]  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         operation,
  input  wire logic [mcts_pkg::CH_W-1:0]    channel,
  input  wire logic [mcts_pkg::DATA_W-1:0]  timestamp,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [mcts_pkg::CH_W-1:0]         result_channel,
  output logic [mcts_pkg::DATA_W-1:0]       speed
);

  mcts_pkg::cmd_t cmd;
  mcts_pkg::stat_t stat;

  mcts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mcts_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .channel        (channel),
    .timestamp      (timestamp),
    .cmd            (cmd),
    .stat           (stat),
    .result_channel (result_channel),
    .speed          (speed)
  );

endmodule

`default_nettype wire

FILE: rtl/mcts_ctrl.sv
`default_nettype none

module mcts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire mcts_pkg::stat_t stat,
  output mcts_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_FIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [mcts_pkg::CNT_W-1:0] cnt;
  logic [mcts_pkg::CNT_W-1:0] cnt_next;
  logic out_free;
  logic last_step;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign last_step = (cnt == mcts_pkg::CNT_W'(mcts_pkg::DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    cmd.accept = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid && stat.completes) begin
          cmd.div_load = 1'b1;
          cnt_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (last_step) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_step_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && last_step) |=> (state == S_FIN))
    else $error("divider did not finish after last step");

  a_div_begin: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && stat.completes) |=> (state == S_DIV && cnt == '0))
    else $error("completing edge did not start division");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN && out_valid))
    else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/mcts_dp.sv
`default_nettype none

module mcts_dp #(
  parameter int CHANNELS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [mcts_pkg::DATA_W-1:0]  cfg_data,
  input  wire logic                         operation,
  input  wire logic [mcts_pkg::CH_W-1:0]    channel,
  input  wire logic [mcts_pkg::DATA_W-1:0]  timestamp,
  input  wire mcts_pkg::cmd_t               cmd,
  output mcts_pkg::stat_t                   stat,
  output logic [mcts_pkg::CH_W-1:0]         result_channel,
  output logic [mcts_pkg::DATA_W-1:0]       speed
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [mcts_pkg::DATA_W-1:0] ticks;
  logic [CHANNELS-1:0] armed;
  logic [CHANNELS-1:0] edge_pending;
  logic [mcts_pkg::DATA_W-1:0] first_edge_time [CHANNELS];

  logic [31:0] ch_ext;
  logic [IDX_W-1:0] idx;
  logic in_range;
  logic is_edge;
  logic hit;
  logic [mcts_pkg::DATA_W-1:0] diff;
  logic [mcts_pkg::DATA_W-1:0] divisor_next;

  logic [mcts_pkg::DATA_W-1:0] divisor;
  logic [mcts_pkg::DATA_W-1:0] rem;
  logic [mcts_pkg::DATA_W-1:0] quo;
  logic [mcts_pkg::CH_W-1:0] res_ch;
  logic [mcts_pkg::DATA_W:0] rem_sh;
  logic [mcts_pkg::DATA_W:0] trial;

  assign ch_ext = 32'(channel);
  assign idx = ch_ext[IDX_W-1:0];
  assign in_range = (ch_ext < 32'(CHANNELS));
  assign is_edge = (operation == mcts_pkg::OP_EDGE);
  assign hit = is_edge && in_range && armed[idx];
  assign stat.completes = hit && edge_pending[idx];

  assign diff = timestamp - first_edge_time[idx];
  assign divisor_next = (diff == '0) ? mcts_pkg::DATA_W'(1) : diff;

  // restoring divide, one quotient bit per step
  assign rem_sh = {rem, quo[mcts_pkg::DATA_W-1]};
  assign trial = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= mcts_pkg::TICKS_RESET;
    end else if (cfg_write) begin
      ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
      edge_pending <= '0;
    end else if (cmd.accept) begin
      if (operation == mcts_pkg::OP_START) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (!armed[i]) begin
            armed[i] <= 1'b1;
            edge_pending[i] <= 1'b0;
          end
        end
      end else if (hit) begin
        if (edge_pending[idx]) begin
          armed[idx] <= 1'b0;
          edge_pending[idx] <= 1'b0;
        end else begin
          edge_pending[idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && hit && !edge_pending[idx]) begin
      first_edge_time[idx] <= timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      divisor <= divisor_next;
      rem <= '0;
      quo <= ticks;
      res_ch <= channel;
    end else if (cmd.div_step) begin
      if (!trial[mcts_pkg::DATA_W]) begin
        rem <= trial[mcts_pkg::DATA_W-1:0];
        quo <= {quo[mcts_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[mcts_pkg::DATA_W-1:0];
        quo <= {quo[mcts_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      speed <= quo;
      result_channel <= res_ch;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/multi_channel_tach_speed_meter_tb.sv
`timescale 1ns / 1ps

module multi_channel_tach_speed_meter_tb;

  localparam int CHANNELS = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 188;
  localparam int MAX_PRINTS = 60;

  typedef struct packed {
    logic [mcts_pkg::CH_W-1:0]   ch;
    logic [mcts_pkg::DATA_W-1:0] spd;
  } speed_rec_t;

  typedef struct {
    logic                        op;
    logic [mcts_pkg::CH_W-1:0]   ch;
    logic [mcts_pkg::DATA_W-1:0] ts;
    bit                          typed;
    bit                          t_has;
    logic [mcts_pkg::CH_W-1:0]   t_ch;
    logic [mcts_pkg::DATA_W-1:0] t_spd;
  } dir_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [mcts_pkg::DATA_W-1:0] cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        operation = mcts_pkg::OP_START;
  logic [mcts_pkg::CH_W-1:0]   channel = '0;
  logic [mcts_pkg::DATA_W-1:0] timestamp = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [mcts_pkg::CH_W-1:0]   result_channel;
  logic [mcts_pkg::DATA_W-1:0] speed;

  // predictor state
  logic [mcts_pkg::DATA_W-1:0] ticks_setting = mcts_pkg::TICKS_RESET;
  logic [mcts_pkg::DATA_W-1:0] first_edge_ts [CHANNELS];
  bit                          ch_armed [CHANNELS];
  bit                          ch_pending [CHANNELS];

  speed_rec_t expected_speeds [$];
  dir_row_t   dir_rows [$];
  speed_rec_t head_rec;

  int  errors = 0;
  int  items_in = 0;
  int  results_out = 0;
  int  settings_used = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  long_stall_req = 1'b0;

  multi_channel_tach_speed_meter #(.CHANNELS(CHANNELS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .channel(channel),
    .timestamp(timestamp),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_channel(result_channel),
    .speed(speed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic bit tach_predict(input logic op, input logic [mcts_pkg::CH_W-1:0] ch,
                                      input logic [mcts_pkg::DATA_W-1:0] ts,
                                      output speed_rec_t rec);
    logic [mcts_pkg::DATA_W-1:0] diff;
    rec = '0;
    if (op == mcts_pkg::OP_START) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (!ch_armed[i]) begin
          ch_armed[i] = 1'b1;
          ch_pending[i] = 1'b0;
        end
      end
      return 1'b0;
    end
    if (!ch_armed[ch]) return 1'b0;
    if (!ch_pending[ch]) begin
      first_edge_ts[ch] = ts;
      ch_pending[ch] = 1'b1;
      return 1'b0;
    end
    ch_armed[ch] = 1'b0;
    ch_pending[ch] = 1'b0;
    diff = ts - first_edge_ts[ch];
    if (diff == '0) diff = 32'd1;
    rec.ch = ch;
    rec.spd = ticks_setting / diff;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic op, input logic [mcts_pkg::CH_W-1:0] ch,
                                  input logic [mcts_pkg::DATA_W-1:0] ts, input bit typed,
                                  input bit t_has, input logic [mcts_pkg::CH_W-1:0] t_ch,
                                  input logic [mcts_pkg::DATA_W-1:0] t_spd);
    dir_row_t r;
    r.op = op;
    r.ch = ch;
    r.ts = ts;
    r.typed = typed;
    r.t_has = t_has;
    r.t_ch = t_ch;
    r.t_spd = t_spd;
    dir_rows.push_back(r);
  endfunction

  task automatic offer_item(input logic op, input logic [mcts_pkg::CH_W-1:0] ch,
                            input logic [mcts_pkg::DATA_W-1:0] ts);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    channel <= ch;
    timestamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_in++;
  endtask

  task automatic write_ticks(input logic [mcts_pkg::DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    ticks_setting = value;
    settings_used++;
  endtask

  // wait out all results, then the divider latency, before touching the register
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int                          counted;
    logic                        op;
    logic [mcts_pkg::CH_W-1:0]   ch;
    logic [mcts_pkg::DATA_W-1:0] ts;
    bit                          live;
    speed_rec_t                  rec;
    counted = 0;
    while (counted < count) begin
      ch = mcts_pkg::CH_W'($urandom_range(0, CHANNELS - 1));
      ts = $urandom;
      if ($urandom_range(0, 99) < 10) begin
        op = mcts_pkg::OP_START;
      end else begin
        op = mcts_pkg::OP_EDGE;
        if ($urandom_range(0, 4) != 0) begin
          for (int k = 0; k < CHANNELS; k++) begin
            if (!ch_armed[ch]) ch = ch + 1'b1;
          end
        end
        if (ch_pending[ch] && $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 4))
            0: ts = first_edge_ts[ch];
            1: ts = first_edge_ts[ch] + 32'd1;
            2: ts = first_edge_ts[ch] + $urandom_range(2, 1000);
            3: ts = first_edge_ts[ch] + $urandom_range(1000, 1000000);
            default: ts = first_edge_ts[ch] + $urandom;
          endcase
        end
      end
      live = (op == mcts_pkg::OP_START) || ch_armed[ch];
      offer_item(op, ch, ts);
      if (tach_predict(op, ch, ts, rec)) expected_speeds.push_back(rec);
      if (live) counted++;
    end
  endtask

  // receiver: random ready bursts plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_out++;
      if (expected_speeds.size() == 0) begin
        report_mismatch($sformatf("unexpected result ch %0d speed %0d", result_channel, speed));
      end else begin
        head_rec = expected_speeds.pop_front();
        if (result_channel !== head_rec.ch)
          report_mismatch($sformatf("result_channel %0d, want %0d", result_channel, head_rec.ch));
        if (speed !== head_rec.spd)
          report_mismatch($sformatf("speed %0d, want %0d (ch %0d)", speed, head_rec.spd,
                                    head_rec.ch));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("multi_channel_tach_speed_meter_tb: done, errors");
      $finish;
    end
  end

  initial begin
    speed_rec_t                  rec;
    bit                          has;
    logic [mcts_pkg::DATA_W-1:0] setting;
    for (int i = 0; i < CHANNELS; i++) begin
      first_edge_ts[i] = '0;
      ch_armed[i] = 1'b0;
      ch_pending[i] = 1'b0;
    end

    // op, channel, timestamp, typed, has result, channel, speed
    add_row(mcts_pkg::OP_EDGE,  3'd0, 32'd100,        1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_START, 3'd0, 32'd0,          1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd0, 32'd0,          1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd0, 32'd0,          1'b1, 1'b1, 3'd0, 32'd2880000000);
    add_row(mcts_pkg::OP_EDGE,  3'd0, 32'd5,          1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_START, 3'd5, 32'hFFFFFFFF,   1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd7, 32'hFFFFFFFF,   1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd7, 32'd0,          1'b1, 1'b1, 3'd7, 32'd2880000000);
    add_row(mcts_pkg::OP_START, 3'd7, 32'd0,          1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd1, 32'd1000,       1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_START, 3'd1, 32'd0,          1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd1, 32'd2880001000, 1'b1, 1'b1, 3'd1, 32'd1);
    add_row(mcts_pkg::OP_EDGE,  3'd2, 32'd0,          1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd2, 32'hFFFFFFFF,   1'b1, 1'b1, 3'd2, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd3, 32'd12345,      1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd3, 32'd108345,     1'b1, 1'b1, 3'd3, 32'd30000);
    add_row(mcts_pkg::OP_EDGE,  3'd4, 32'd7,          1'b1, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd4, 32'd10,         1'b1, 1'b1, 3'd4, 32'd960000000);
    add_row(mcts_pkg::OP_EDGE,  3'd5, 32'h80000000,   1'b0, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd5, 32'h7FFFFFFF,   1'b0, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd6, 32'hAAAAAAAA,   1'b0, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd6, 32'h55555555,   1'b0, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd0, 32'd0,          1'b0, 1'b0, 3'd0, 32'd0);
    add_row(mcts_pkg::OP_EDGE,  3'd0, 32'hDEADBEEF,   1'b0, 1'b0, 3'd0, 32'd0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      offer_item(dir_rows[k].op, dir_rows[k].ch, dir_rows[k].ts);
      has = tach_predict(dir_rows[k].op, dir_rows[k].ch, dir_rows[k].ts, rec);
      if (dir_rows[k].typed) begin
        has = dir_rows[k].t_has;
        rec.ch = dir_rows[k].t_ch;
        rec.spd = dir_rows[k].t_spd;
      end
      if (has) expected_speeds.push_back(rec);
    end
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: setting = 32'hFFFFFFFF;
        1: setting = 32'd1;
        2: setting = 32'd0;
        3: setting = $urandom;
        4: setting = 32'd96000000;
        default: setting = mcts_pkg::TICKS_RESET;
      endcase
      write_ticks(setting);
      quiet = (p == NUM_PHASES - 1);
      // long output hold-off so the result register fills and the input backs up
      if (p == 1) long_stall_req = 1'b1;
      random_phase(ITEMS_PER_PHASE);
      settle();
    end

    $display("run covered %0d input transactions and %0d results", items_in, results_out);
    $display("across %0d register settings plus the reset value, %0d mismatches",
             settings_used, errors);
    if (errors == 0) begin
      $display("multi_channel_tach_speed_meter_tb: done, clean");
    end else begin
      $display("multi_channel_tach_speed_meter_tb: done, errors");
    end
    $finish;
  end

endmodule
